// ===== hdl/assert_macros.svh =====
// assert_macros.svh: assertion macros shared by the two-lane ALU RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off during reset
`define AST_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: lbl failed");

// implication with a fixed delay in cycles
`define AST_DLY(lbl, clk, rstn, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##dly (cons)) \
    else $error("%m: lbl failed");

`endif

// ===== hdl/ta64_pkg.sv =====
// ta64_pkg: types and constants of the two-lane 64-bit ALU.
// No dependencies.
`timescale 1ns / 1ps
package ta64_pkg;
  localparam int W   = 64;
  localparam int LAT = W + 2;  // operand stage, W divide steps, result stage

  typedef logic [2:0] func_t;
  localparam func_t FN_NEG = 3'd0;
  localparam func_t FN_ABS = 3'd1;
  localparam func_t FN_MIN = 3'd2;
  localparam func_t FN_MAX = 3'd3;
  localparam func_t FN_QUO = 3'd4;
  localparam func_t FN_REM = 3'd5;

  typedef struct packed {
    logic         is_q;
    logic         is_r;
    logic         zdiv;
    logic         neg_q;
    logic         neg_r;
    logic [W-1:0] simple;
  } ctl_t;
endpackage

// ===== hdl/ta64_div_step.sv =====
// ta64_div_step: one registered restoring-division step (one quotient bit).
// Depends on ta64_pkg.
`timescale 1ns / 1ps
module ta64_div_step (
  input  logic                 clk,
  input  logic [ta64_pkg::W-1:0] rem_i,
  input  logic [ta64_pkg::W-1:0] quo_i,
  input  logic [ta64_pkg::W-1:0] den_i,
  input  ta64_pkg::ctl_t       ctl_i,
  output logic [ta64_pkg::W-1:0] rem_o,
  output logic [ta64_pkg::W-1:0] quo_o,
  output logic [ta64_pkg::W-1:0] den_o,
  output ta64_pkg::ctl_t       ctl_o
);
  import ta64_pkg::*;

  logic [W:0]   trial;
  logic [W-1:0] rem_nxt, quo_nxt;

  always_comb begin
    trial = {rem_i, quo_i[W-1]} - {1'b0, den_i};
    if (!trial[W]) begin
      rem_nxt = trial[W-1:0];
      quo_nxt = {quo_i[W-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_i[W-2:0], quo_i[W-1]};
      quo_nxt = {quo_i[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    rem_o <= rem_nxt;
    quo_o <= quo_nxt;
    den_o <= den_i;
    ctl_o <= ctl_i;
  end
endmodule

// ===== hdl/ta64_lane.sv =====
// ta64_lane: one ALU lane: operand stage, pipelined divider, result stage.
// Depends on ta64_pkg, ta64_div_step, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ta64_lane (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ta64_pkg::func_t        func,
  input  logic [ta64_pkg::W-1:0] a,
  input  logic [ta64_pkg::W-1:0] b,
  output logic [ta64_pkg::W-1:0] res,
  output logic                   zdiv
);
  import ta64_pkg::*;

  logic [W-1:0] rem_s [0:W];
  logic [W-1:0] quo_s [0:W];
  logic [W-1:0] den_s [0:W];
  ctl_t         ctl_s [0:W];

  logic [W-1:0] neg_a, mag_a, mag_b, simple;
  logic         a_lt_b;
  ctl_t         ctl0;
  logic [W-1:0] res_r, res_nxt;
  logic         zdiv_r, zdiv_nxt;

  always_comb begin
    neg_a  = -a;
    mag_a  = a[W-1] ? neg_a : a;
    mag_b  = b[W-1] ? -b : b;
    a_lt_b = $signed(a) < $signed(b);
    case (func)
      FN_NEG:  simple = neg_a;
      FN_ABS:  simple = mag_a;
      FN_MIN:  simple = a_lt_b ? a : b;
      FN_MAX:  simple = a_lt_b ? b : a;
      default: simple = '0;
    endcase
    ctl0.is_q   = (func == FN_QUO);
    ctl0.is_r   = (func == FN_REM);
    ctl0.zdiv   = (ctl0.is_q | ctl0.is_r) && (b == '0);
    ctl0.neg_q  = a[W-1] ^ b[W-1];
    ctl0.neg_r  = a[W-1];
    ctl0.simple = simple;
  end

  always_ff @(posedge clk) begin
    rem_s[0] <= '0;
    quo_s[0] <= mag_a;
    den_s[0] <= mag_b;
    ctl_s[0] <= ctl0;
  end

  for (genvar i = 0; i < W; i++) begin : g_step
    ta64_div_step u_step (
      .clk  (clk),
      .rem_i(rem_s[i]),
      .quo_i(quo_s[i]),
      .den_i(den_s[i]),
      .ctl_i(ctl_s[i]),
      .rem_o(rem_s[i+1]),
      .quo_o(quo_s[i+1]),
      .den_o(den_s[i+1]),
      .ctl_o(ctl_s[i+1])
    );
  end

  always_comb begin
    zdiv_nxt = ctl_s[W].zdiv;
    if (ctl_s[W].zdiv)
      res_nxt = '0;
    else if (ctl_s[W].is_q)
      res_nxt = ctl_s[W].neg_q ? -quo_s[W] : quo_s[W];
    else if (ctl_s[W].is_r)
      res_nxt = ctl_s[W].neg_r ? -rem_s[W] : rem_s[W];
    else
      res_nxt = ctl_s[W].simple;
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    zdiv_r <= zdiv_nxt;
  end

  assign res  = res_r;
  assign zdiv = zdiv_r;

  `AST_IMPL(a_zdiv_res_zero, clk, rst_n, zdiv_r, res_r == '0)
endmodule

// ===== hdl/two_lane_int64_alu_top.sv =====
// Two-lane signed 64-bit ALU: neg, abs, min, max, quotient, remainder.
// Every operation takes the same path from accept to out_strobe
// (operand stage, 64 one-bit divide steps per lane, result stage).
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Reset (rst_n, synchronous) clears only the valid chain; data regs are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module two_lane_int64_alu_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             in_func,
  input  logic signed [63:0]     in_a_lo,
  input  logic signed [63:0]     in_a_hi,
  input  logic signed [63:0]     in_b_lo,
  input  logic signed [63:0]     in_b_hi,
  output logic                   out_strobe,
  output logic signed [63:0]     out_res_lo,
  output logic signed [63:0]     out_res_hi,
  output logic                   out_zero_div_lo,
  output logic                   out_zero_div_hi
);
  import ta64_pkg::*;

  logic [LAT-1:0] vld_r, vld_nxt;
  logic           accept;
  logic [W-1:0]   res0, res1;
  logic           zd0, zd1;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  ta64_lane u_lane0 (
    .clk(clk), .rst_n(rst_n), .func(in_func), .a(in_a_lo), .b(in_b_lo),
    .res(res0), .zdiv(zd0)
  );
  ta64_lane u_lane1 (
    .clk(clk), .rst_n(rst_n), .func(in_func), .a(in_a_hi), .b(in_b_hi),
    .res(res1), .zdiv(zd1)
  );

  assign vld_nxt = {vld_r[LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // merge the lanes; flags qualified by the item strobe
  assign out_strobe      = vld_r[LAT-1];
  assign out_res_lo      = res0;
  assign out_res_hi      = res1;
  assign out_zero_div_lo = zd0 & out_strobe;
  assign out_zero_div_hi = zd1 & out_strobe;

  `AST_DLY(a_item_out, clk, rst_n, accept, LAT, out_strobe)
  `AST_IMPL(a_flags_idle, clk, rst_n, !out_strobe, !out_zero_div_lo && !out_zero_div_hi)
endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for two_lane_int64_alu_top.
// Predicts each item's lane results from its own model of the ALU and
// checks every strobed result in order. Depends on ta64_pkg.
`timescale 1ns / 1ps
module testbench;
  import ta64_pkg::*;

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
  localparam func_t FN_BAD6 = 3'd6;
  localparam func_t FN_BAD7 = 3'd7;

  typedef struct {
    logic [63:0] res_lo;
    logic [63:0] res_hi;
    logic        zd_lo;
    logic        zd_hi;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_func = '0;
  logic signed [63:0] in_a_lo = '0, in_a_hi = '0, in_b_lo = '0, in_b_hi = '0;
  logic out_strobe;
  logic signed [63:0] out_res_lo, out_res_hi;
  logic out_zero_div_lo, out_zero_div_hi;

  alu_result_t pending_results[$];
  int mismatches = 0;
  int send_idle_pct = 0;

  always #5 clk = ~clk;

  two_lane_int64_alu_top dut (.*);

  function automatic logic [63:0] mag(logic [63:0] x);
    return x[63] ? -x : x;
  endfunction

  function automatic logic [63:0] lane_calc(func_t f, logic [63:0] a, logic [63:0] b,
                                            output logic zd);
    logic [63:0] q;
    zd = 1'b0;
    case (f)
      FN_NEG: return -a;
      FN_ABS: return mag(a);
      FN_MIN: return ($signed(a) < $signed(b)) ? a : b;
      FN_MAX: return ($signed(b) < $signed(a)) ? a : b;
      FN_QUO, FN_REM: begin
        if (b == 0) begin
          zd = 1'b1;
          return 64'd0;
        end
        if (f == FN_QUO) begin
          q = mag(a) / mag(b);
          return (a[63] != b[63]) ? -q : q;
        end
        q = mag(a) % mag(b);
        return a[63] ? -q : q;
      end
      default: return 64'd0;
    endcase
  endfunction

  // drive one item and wait for it to be taken
  task automatic send_item(func_t f, logic [63:0] alo, logic [63:0] ahi,
                           logic [63:0] blo, logic [63:0] bhi);
    alu_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_a_lo <= alo;
    in_a_hi <= ahi;
    in_b_lo <= blo;
    in_b_hi <= bhi;
    do @(posedge clk); while (busy);
    r.res_lo = lane_calc(f, alo, blo, r.zd_lo);
    r.res_hi = lane_calc(f, ahi, bhi, r.zd_hi);
    pending_results.push_back(r);
  endtask

  task automatic idle_input();
    start <= 1'b0;
  endtask

  // operand biased toward edge values
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(9))
      0: return MIN64;
      1: return MAX64;
      2: return 64'd0;
      3: return -64'sd1;
      4: return 64'd1;
      5: return {{56{1'b0}}, 8'($urandom)} - 64'd128;
      6: return {32'(0), $urandom} >> $urandom_range(31);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_directed();
    func_t f;
    for (int i = 0; i < 8; i++) begin
      f = func_t'(i);
      send_item(f, MIN64, MAX64, -64'sd1, 64'd0);
      send_item(f, 64'd7, -64'sd7, 64'd2, -64'sd2);
    end
    send_item(FN_QUO, MIN64, -64'sd7, -64'sd1, 64'd2);
    send_item(FN_REM, MIN64, -64'sd7, -64'sd1, 64'd2);
    send_item(FN_QUO, MAX64, MIN64, MIN64, MAX64);
    send_item(FN_REM, MAX64, MIN64, MIN64, MAX64);
    send_item(FN_MIN, -64'sd1, 64'd0, 64'd0, -64'sd1);
    send_item(FN_MAX, -64'sd1, 64'd0, 64'd0, -64'sd1);
    send_item(FN_QUO, 64'd0, 64'd5, 64'd0, 64'd0);
    idle_input();
  endtask

  task automatic test_random(int n, int pct);
    func_t f;
    send_idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      // unused codes now and then
      if ($urandom_range(7) == 0)
        f = ($urandom_range(1) == 0) ? FN_BAD6 : FN_BAD7;
      else
        f = func_t'($urandom_range(5));
      send_item(f, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    idle_input();
  endtask

  always @(posedge clk) begin
    alu_result_t e;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h", out_res_lo, out_res_hi);
      end else begin
        e = pending_results.pop_front();
        if (out_res_lo !== e.res_lo || out_res_hi !== e.res_hi ||
            out_zero_div_lo !== e.zd_lo || out_zero_div_hi !== e.zd_hi) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %b%b got %h %h %b%b", e.res_lo, e.res_hi,
                     e.zd_lo, e.zd_hi, out_res_lo, out_res_hi,
                     out_zero_div_lo, out_zero_div_hi);
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(550, 8);
    test_random(550, 69);
    test_random(500, 0);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule

// ===== two_lane_int64_alu_top.f =====
+incdir+hdl
hdl/ta64_pkg.sv
hdl/ta64_div_step.sv
hdl/ta64_lane.sv
hdl/two_lane_int64_alu_top.sv
tb/testbench.sv
